// ===== design/mwnq_pkg.sv =====
`timescale 1ns / 1ps
// shared types and codes for the max weight node queue
package mwnq_pkg;

   // request function codes
   typedef enum logic [1:0] {
      FUNC_RESTART  = 2'd0,
      FUNC_INCREASE = 2'd1,
      FUNC_POP      = 2'd2,
      FUNC_READ     = 2'd3
   } func_type;

   // response status codes
   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_RANGE = 2'd2
   } status_type;

   // summary of one scan pass over the active nodes
   typedef struct packed {
      logic found;   // at least one present node seen
      logic multi;   // at least two present nodes seen
   } scan_flags_type;

endpackage

// ===== design/mwnq_scan.sv =====
`timescale 1ns / 1ps
// shared compare unit that walks the node memory for the maximum present weight
module mwnq_scan import mwnq_pkg::*; #(
   parameter int NODE_W       = 6,
   parameter int WEIGHT_WIDTH = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    scan_start,
   input  logic                    issue,
   input  logic [NODE_W-1:0]       issue_addr,
   input  logic [NODE_W-1:0]       target_addr,
   input  logic                    rd_present,
   input  logic [WEIGHT_WIDTH-1:0] rd_weight,
   output scan_flags_type          flags,
   output logic [NODE_W-1:0]       best_node,
   output logic [WEIGHT_WIDTH-1:0] best_weight,
   output logic [WEIGHT_WIDTH-1:0] target_weight
);

   logic                    vld_ff, vld_in;
   logic [NODE_W-1:0]       addr_ff;
   logic                    found_ff, found_in;
   logic                    multi_ff, multi_in;
   logic [NODE_W-1:0]       best_idx_ff, best_idx_in;
   logic [WEIGHT_WIDTH-1:0] best_w_ff, best_w_in;
   logic [WEIGHT_WIDTH-1:0] tgt_w_ff, tgt_w_in;
   logic                    take;
   logic                    hit;

   // the one comparator: ties go to the later, higher index
   assign take = vld_ff && rd_present && (!found_ff || (rd_weight >= best_w_ff));
   assign hit  = vld_ff && (addr_ff == target_addr);

   // accumulate the running maximum
   always_comb begin
      vld_in      = issue;
      found_in    = found_ff;
      multi_in    = multi_ff;
      best_idx_in = best_idx_ff;
      best_w_in   = best_w_ff;
      tgt_w_in    = tgt_w_ff;
      if (scan_start) begin
         found_in = 1'b0;
         multi_in = 1'b0;
      end else begin
         if (vld_ff && rd_present) begin
            found_in = 1'b1;
            multi_in = multi_ff | found_ff;
         end
         if (take) begin
            best_idx_in = addr_ff;
            best_w_in   = rd_weight;
         end
         if (hit) begin
            tgt_w_in = rd_weight;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff   <= 1'b0;
         found_ff <= 1'b0;
         multi_ff <= 1'b0;
      end else begin
         vld_ff   <= vld_in;
         found_ff <= found_in;
         multi_ff <= multi_in;
      end
   end

   // data registers
   always_ff @(posedge clock) begin
      addr_ff     <= issue_addr;
      best_idx_ff <= best_idx_in;
      best_w_ff   <= best_w_in;
      tgt_w_ff    <= tgt_w_in;
   end

   assign flags.found   = found_ff;
   assign flags.multi   = multi_ff;
   assign best_node     = best_idx_ff;
   assign best_weight   = best_w_ff;
   assign target_weight = tgt_w_ff;

endmodule

// ===== design/max_weight_node_queue_core.sv =====
`timescale 1ns / 1ps
// max weight node queue: sequencer, node memory and response registers
//
// Max-priority queue of node indices keyed by a saturating per-node weight.
// Pop, increase and read each walk the active nodes (node_count saturated to
// MAX_NODES) once through a single read port of the node memory and one shared
// comparator, so busy stays high through the scan and the finish step, and the
// next item can start in the cycle the result is strobed. Restart rewrites every
// memory entry, one per cycle, then runs the finish step, all with busy high.
// After reset the same clearing pass runs with busy high; configuration writes
// are taken during it. Each result is shown for exactly one cycle with rsp_valid
// and cannot be held off.
module max_weight_node_queue_core import mwnq_pkg::*; #(
   parameter int MAX_NODES    = 64,
   parameter int WEIGHT_WIDTH = 16,
   localparam int NODE_W      = $clog2(MAX_NODES),
   localparam int CNT_W       = $clog2(MAX_NODES + 1)
) (
   input  logic                    clock,
   input  logic                    reset,
   // request
   input  logic                    start,
   output logic                    busy,
   input  logic [1:0]              req_func,
   input  logic [NODE_W-1:0]       req_node_index,
   // response
   output logic                    rsp_valid,
   output logic [NODE_W-1:0]       rsp_result_node,
   output logic [WEIGHT_WIDTH-1:0] rsp_result_weight,
   output logic                    rsp_queue_empty,
   output logic [1:0]              rsp_status,
   // node count register
   input  logic                    csr_wr_en,
   input  logic [CNT_W-1:0]        csr_wr_data
);

   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_NODES);

   typedef enum logic [3:0] {
      ST_CLEAR  = 4'b0001,
      ST_IDLE   = 4'b0010,
      ST_SCAN   = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   state_type               state_ff, state_in;
   logic [CNT_W-1:0]        ptr_ff, ptr_in;
   logic                    clear_out_ff, clear_out_in;
   func_type                func_ff, func_in;
   logic [NODE_W-1:0]       idx_ff, idx_in;
   logic [CNT_W-1:0]        node_count_ff;
   logic [CNT_W-1:0]        n_active;
   logic                    idx_in_range;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [NODE_W-1:0]       rsp_node_ff, rsp_node_in;
   logic [WEIGHT_WIDTH-1:0] rsp_weight_ff, rsp_weight_in;
   logic                    rsp_empty_ff, rsp_empty_in;
   status_type              rsp_status_ff, rsp_status_in;

   logic [WEIGHT_WIDTH:0]   node_mem [MAX_NODES];
   logic [WEIGHT_WIDTH:0]   mem_rd_ff;
   logic                    wr_en;
   logic [NODE_W-1:0]       wr_addr;
   logic [WEIGHT_WIDTH:0]   wr_data;
   logic                    rd_en;
   logic [NODE_W-1:0]       rd_addr;

   logic                    scan_start;
   scan_flags_type          scan_flags;
   logic [NODE_W-1:0]       best_node;
   logic [WEIGHT_WIDTH-1:0] best_weight;
   logic [WEIGHT_WIDTH-1:0] target_weight;
   logic [WEIGHT_WIDTH-1:0] inc_weight;

   // node count register, active count saturated to the memory depth
   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= MAX_CNT;
      end else if (csr_wr_en) begin
         node_count_ff <= csr_wr_data;
      end
   end

   assign n_active     = (node_count_ff > MAX_CNT) ? MAX_CNT : node_count_ff;
   assign idx_in_range = CNT_W'(idx_ff) < n_active;
   assign inc_weight   = (target_weight == '1) ? target_weight
                                               : WEIGHT_WIDTH'(target_weight + 1'b1);

   // node memory: present flag over weight
   always_ff @(posedge clock) begin
      if (wr_en) begin
         node_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         mem_rd_ff <= node_mem[rd_addr];
      end
   end

   // maximum search over the scanned entries
   mwnq_scan #(
      .NODE_W       (NODE_W),
      .WEIGHT_WIDTH (WEIGHT_WIDTH)
   ) u_scan (
      .clock         (clock),
      .reset         (reset),
      .scan_start    (scan_start),
      .issue         (rd_en),
      .issue_addr    (rd_addr),
      .target_addr   (idx_ff),
      .rd_present    (mem_rd_ff[WEIGHT_WIDTH]),
      .rd_weight     (mem_rd_ff[WEIGHT_WIDTH-1:0]),
      .flags         (scan_flags),
      .best_node     (best_node),
      .best_weight   (best_weight),
      .target_weight (target_weight)
   );

   // sequencer
   always_comb begin
      state_in      = state_ff;
      ptr_in        = ptr_ff;
      clear_out_in  = clear_out_ff;
      func_in       = func_ff;
      idx_in        = idx_ff;
      wr_en         = 1'b0;
      wr_addr       = ptr_ff[NODE_W-1:0];
      wr_data       = '0;
      rd_en         = 1'b0;
      rd_addr       = ptr_ff[NODE_W-1:0];
      scan_start    = 1'b0;
      rsp_valid_in  = 1'b0;
      rsp_node_in   = rsp_node_ff;
      rsp_weight_in = rsp_weight_ff;
      rsp_empty_in  = rsp_empty_ff;
      rsp_status_in = rsp_status_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            // rewrite one entry a cycle; after reset every node is present
            wr_en   = 1'b1;
            wr_data = {(clear_out_ff ? (ptr_ff < n_active) : 1'b1),
                       {WEIGHT_WIDTH{1'b0}}};
            ptr_in  = CNT_W'(ptr_ff + 1'b1);
            if (ptr_ff == CNT_W'(MAX_NODES - 1)) begin
               state_in = clear_out_ff ? ST_FINISH : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               func_in = func_type'(req_func);
               idx_in  = req_node_index;
               ptr_in  = '0;
               if (func_type'(req_func) == FUNC_RESTART) begin
                  clear_out_in = 1'b1;
                  state_in     = ST_CLEAR;
               end else begin
                  scan_start = 1'b1;
                  state_in   = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            // one read per cycle; the last entry lands as the pointer hits the end
            if (ptr_ff < n_active) begin
               rd_en  = 1'b1;
               ptr_in = CNT_W'(ptr_ff + 1'b1);
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
            unique case (func_ff) inside
               FUNC_RESTART: begin
                  rsp_node_in   = '0;
                  rsp_weight_in = '0;
                  rsp_empty_in  = (n_active == '0);
                  rsp_status_in = STATUS_OK;
               end
               FUNC_POP: begin
                  if (scan_flags.found) begin
                     wr_en         = 1'b1;
                     wr_addr       = best_node;
                     wr_data       = {1'b0, best_weight};
                     rsp_node_in   = best_node;
                     rsp_weight_in = best_weight;
                     rsp_empty_in  = !scan_flags.multi;
                     rsp_status_in = STATUS_OK;
                  end else begin
                     rsp_node_in   = '0;
                     rsp_weight_in = '0;
                     rsp_empty_in  = 1'b1;
                     rsp_status_in = STATUS_EMPTY;
                  end
               end
               FUNC_INCREASE, FUNC_READ: begin
                  rsp_node_in = idx_ff;
                  if (!idx_in_range) begin
                     rsp_weight_in = '0;
                     rsp_empty_in  = !scan_flags.found;
                     rsp_status_in = STATUS_RANGE;
                  end else if (func_ff == FUNC_INCREASE) begin
                     wr_en         = 1'b1;
                     wr_addr       = idx_ff;
                     wr_data       = {1'b1, inc_weight};
                     rsp_weight_in = inc_weight;
                     rsp_empty_in  = 1'b0;
                     rsp_status_in = STATUS_OK;
                  end else begin
                     rsp_weight_in = target_weight;
                     rsp_empty_in  = !scan_flags.found;
                     rsp_status_in = STATUS_OK;
                  end
               end
               default: begin
                  rsp_status_in = STATUS_OK;
               end
            endcase
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         ptr_ff       <= '0;
         clear_out_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         clear_out_ff <= clear_out_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // request and response payload
   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      idx_ff        <= idx_in;
      rsp_node_ff   <= rsp_node_in;
      rsp_weight_ff <= rsp_weight_in;
      rsp_empty_ff  <= rsp_empty_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign busy              = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_result_node   = rsp_node_ff;
   assign rsp_result_weight = rsp_weight_ff;
   assign rsp_queue_empty   = rsp_empty_ff;
   assign rsp_status        = rsp_status_ff;

   // checks
   a_rsp_after_finish: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == ST_FINISH))
      else $error("response strobe without a finish step");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not raise busy");

   a_empty_pop_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_EMPTY) |-> (rsp_queue_empty && rsp_result_weight == '0))
      else $error("empty pop reported a weight or a non-empty queue");

   a_scan_flags: assert property (@(posedge clock) disable iff (reset)
      scan_flags.multi |-> scan_flags.found)
      else $error("scan saw two nodes but none found");

   a_increase_not_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_OK && $past(func_ff == FUNC_INCREASE))
         |-> !rsp_queue_empty)
      else $error("queue reported empty after an increase");

endmodule
